// File: rtl/pidad_pkg.sv
package pidad_pkg;

   // Fixed-point formats
   localparam int TEMP_FRAC_BITS  = 8;
   localparam int GAIN_FRAC_BITS  = 10;
   localparam int INTEG_FRAC_BITS = 16;

   // Field and register widths
   localparam int SETPOINT_W  = 8;
   localparam int TEMP_W      = 17;
   localparam int DRIVE_W     = 10;
   localparam int GAIN_P_W    = 16;
   localparam int GAIN_I_W    = 14;
   localparam int GAIN_D_W    = 15;
   localparam int LIMIT_W     = 16;
   localparam int PERIOD_W    = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // Control constants
   localparam int DRIVE_MAX     = 1000;
   localparam int INTEG_DIVISOR = 100;
   localparam int DERIV_SCALE   = 20;

   // Error: setpoint aligned to Q.TEMP minus measured temperature
   localparam int SP_ALIGN_W = SETPOINT_W + TEMP_FRAC_BITS;
   localparam int ERR_W      = ((SP_ALIGN_W > TEMP_W) ? SP_ALIGN_W : TEMP_W) + 1;
   localparam int MAG_W      = ERR_W - 1;

   // Integral increment: round(|err| * 2^(INTEG-TEMP) / 100) by reciprocal multiply
   localparam int INC_SHIFT   = INTEG_FRAC_BITS - TEMP_FRAC_BITS;
   localparam int INC_X_W     = MAG_W + INC_SHIFT + 1;
   localparam int RECIP_SHIFT = INC_X_W + 7;
   localparam int RECIP_W     = RECIP_SHIFT - 6;
   localparam longint unsigned RECIP =
      ((64'd1 << RECIP_SHIFT) + 64'(INTEG_DIVISOR - 1)) / 64'(INTEG_DIVISOR);
   localparam int INC_PROD_W  = INC_X_W + RECIP_W;
   localparam int INC_Q_W     = INC_PROD_W - RECIP_SHIFT;
   localparam int INC_W       = INC_Q_W + 1;

   // Integral accumulator
   localparam int ACC_W   = 28;
   localparam longint ACC_MAX = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
   localparam int LIMQ_W  = LIMIT_W + INTEG_FRAC_BITS + 1;
   localparam int CMP_W   = ((LIMQ_W > ACC_W) ? LIMQ_W : ACC_W) + 1;

   // Derivative
   localparam int DIFF_W    = ERR_W + 1;
   localparam int GD20_W    = GAIN_D_W + 5;
   localparam int DPROD_W   = DIFF_W + GD20_W + 1;
   localparam int HELD_W    = 32;
   localparam longint DERIV_MAX = (64'sd1 <<< (HELD_W - 1)) - 64'sd1;

   // Term widths and final sum
   localparam int P_W     = ERR_W + GAIN_P_W + 1;
   localparam int I_W     = ACC_W + GAIN_I_W + 1;
   localparam int PD_W    = ((P_W > HELD_W) ? P_W : HELD_W) + 1;
   localparam int SUM_A_W = PD_W + INTEG_FRAC_BITS;
   localparam int SUM_B_W = I_W + TEMP_FRAC_BITS;
   localparam int SUM_W   = ((SUM_A_W > SUM_B_W) ? SUM_A_W : SUM_B_W) + 1;
   localparam int RND_SHIFT = TEMP_FRAC_BITS + INTEG_FRAC_BITS + GAIN_FRAC_BITS;
   localparam int RND_W   = SUM_W - RND_SHIFT;

   // Register reset values
   localparam logic [GAIN_P_W-1:0] GAIN_P_RST = GAIN_P_W'(1024);
   localparam logic [GAIN_I_W-1:0] GAIN_I_RST = GAIN_I_W'(1024);
   localparam logic [GD20_W-1:0]   GD20_RST   = GD20_W'(1024 * DERIV_SCALE);
   localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(1000);
   localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(500);

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_GAIN_P       = CSR_INDEX_W'(0);
   localparam csr_index_type CSR_GAIN_I       = CSR_INDEX_W'(1);
   localparam csr_index_type CSR_GAIN_D       = CSR_INDEX_W'(2);
   localparam csr_index_type CSR_WINDUP_LIMIT = CSR_INDEX_W'(3);
   localparam csr_index_type CSR_DERIV_PERIOD = CSR_INDEX_W'(4);

   // Live configuration; derivative gain is kept premultiplied by the scale
   typedef struct packed {
      logic [GAIN_P_W-1:0] gain_p;
      logic [GAIN_I_W-1:0] gain_i;
      logic [GD20_W-1:0]   gain_d20;
      logic [LIMIT_W-1:0]  windup_limit;
      logic [PERIOD_W-1:0] derivative_period;
   } cfg_type;

endpackage

// File: rtl/pidad_csr.sv
module pidad_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wen,
   input  pidad_pkg::csr_index_type            csr_index,
   input  logic [pidad_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output pidad_pkg::cfg_type                  cfg
);
   import pidad_pkg::*;

   cfg_type            cfg_ff;
   logic [GD20_W-1:0]  gain_d20_in;

   // scale folded in at write time so the datapath needs one multiplier for D
   assign gain_d20_in = GD20_W'(csr_wdata[GAIN_D_W-1:0]) * GD20_W'(DERIV_SCALE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p            <= GAIN_P_RST;
         cfg_ff.gain_i            <= GAIN_I_RST;
         cfg_ff.gain_d20          <= GD20_RST;
         cfg_ff.windup_limit      <= LIMIT_RST;
         cfg_ff.derivative_period <= PERIOD_RST;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_GAIN_P:       cfg_ff.gain_p            <= csr_wdata[GAIN_P_W-1:0];
            CSR_GAIN_I:       cfg_ff.gain_i            <= csr_wdata[GAIN_I_W-1:0];
            CSR_GAIN_D:       cfg_ff.gain_d20          <= gain_d20_in;
            CSR_WINDUP_LIMIT: cfg_ff.windup_limit      <= csr_wdata[LIMIT_W-1:0];
            CSR_DERIV_PERIOD: cfg_ff.derivative_period <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/pid_antiwindup_decimated_derivative_core.sv
// PID temperature controller with integrator clamp and decimated derivative.
//
// Request channel (req_*): one control tick, an integer setpoint and a measured
// temperature in Q.8. Accepted when req_valid is high and req_stall is low.
// Response channel (rsp_*): drive 0..1000 plus clip flags, one per request,
// in order. Taken when rsp_valid is high and rsp_stall is low.
// Config port (csr_*): single-cycle writes of gains, windup limit and
// derivative period; write only while no request is in flight.
//
// Six register stages: input, products/derivative, accumulator,
// integral product, sum, output. One request per cycle is taken in steady
// state while rsp_stall stays low; the accumulator and derivative updates
// each close in a single stage.
// Stages move independently: empty stages fill even while the output is
// stalled, so req_stall rises only once every stage holds a request.
// Synchronous reset clears the pipeline, the accumulator, the previous
// error, the tick counter, the held D term and restores register defaults.
module pid_antiwindup_decimated_derivative_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [pidad_pkg::SETPOINT_W-1:0]    req_setpoint,
   input  logic [pidad_pkg::TEMP_W-1:0]        req_measured_temp,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [pidad_pkg::DRIVE_W-1:0]       rsp_drive,
   output logic                                rsp_clipped_high,
   output logic                                rsp_clipped_low,
   input  logic                                csr_wen,
   input  pidad_pkg::csr_index_type            csr_index,
   input  logic [pidad_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pidad_pkg::*;

   cfg_type cfg;

   pidad_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // ---------------------------------------------------------------------
   // Stage valids and load enables. A stage loads when empty or draining.
   // ---------------------------------------------------------------------
   logic va_ff, vb_ff, vc_ff, vd_ff, ve_ff, rsp_valid_ff;
   logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_f;

   assign ld_f = !rsp_valid_ff || !rsp_stall;
   assign ld_e = !ve_ff || ld_f;
   assign ld_d = !vd_ff || ld_e;
   assign ld_c = !vc_ff || ld_d;
   assign ld_b = !vb_ff || ld_c;
   assign ld_a = !va_ff || ld_b;

   assign req_stall = !ld_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         ve_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ld_a) va_ff        <= req_valid;
         if (ld_b) vb_ff        <= va_ff;
         if (ld_c) vc_ff        <= vb_ff;
         if (ld_d) vd_ff        <= vc_ff;
         if (ld_e) ve_ff        <= vd_ff;
         if (ld_f) rsp_valid_ff <= ve_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage A: error = setpoint (aligned to Q.TEMP) - measured temperature
   // ---------------------------------------------------------------------
   logic [ERR_W-1:0]        sp_ext, meas_ext;
   logic signed [ERR_W-1:0] err_a_in, err_a_ff;

   assign sp_ext   = ERR_W'({req_setpoint, {TEMP_FRAC_BITS{1'b0}}});
   assign meas_ext = ERR_W'(req_measured_temp);
   assign err_a_in = $signed(sp_ext - meas_ext);

   always_ff @(posedge clock) begin
      if (ld_a) err_a_ff <= err_a_in;
   end

   // ---------------------------------------------------------------------
   // Stage B: P product, integral increment, derivative refresh
   // ---------------------------------------------------------------------
   logic                      err_neg;
   logic [ERR_W-1:0]          err_abs;
   logic [MAG_W-1:0]          err_mag;
   logic [INC_X_W-1:0]        inc_x;
   logic [INC_PROD_W-1:0]     inc_prod;
   logic [INC_Q_W-1:0]        inc_q;
   logic signed [INC_W-1:0]   inc_b_in, inc_b_ff;
   logic signed [P_W-1:0]     p_b_in, p_b_ff;

   assign err_neg = err_a_ff[ERR_W-1];
   assign err_abs = err_neg ? ERR_W'(-err_a_ff) : ERR_W'(err_a_ff);
   assign err_mag = err_abs[MAG_W-1:0];

   // round half away from zero: (|e|*2^shift + 50) / 100, exact by reciprocal
   assign inc_x    = (INC_X_W'(err_mag) << INC_SHIFT) + INC_X_W'(INTEG_DIVISOR / 2);
   assign inc_prod = INC_PROD_W'(inc_x) * INC_PROD_W'(RECIP);
   assign inc_q    = inc_prod[RECIP_SHIFT +: INC_Q_W];
   assign inc_b_in = err_neg ? -$signed({1'b0, inc_q}) : $signed({1'b0, inc_q});

   assign p_b_in = err_a_ff * $signed({1'b0, cfg.gain_p});

   // derivative: refresh every derivative_period ticks
   logic [PERIOD_W-1:0]        tick_ff, tick_inc, tick_in;
   logic                       d_fire;
   logic signed [ERR_W-1:0]    prev_err_ff;
   logic signed [DIFF_W-1:0]   d_diff;
   logic signed [DPROD_W-1:0]  d_prod, d_lim_pos, d_lim_neg;
   logic signed [HELD_W-1:0]   d_sat, held_d_ff, d_b_in, d_b_ff;

   assign tick_inc = tick_ff + PERIOD_W'(1);
   assign d_fire   = (tick_inc >= cfg.derivative_period);
   assign tick_in  = d_fire ? '0 : tick_inc;

   assign d_diff    = DIFF_W'(err_a_ff) - DIFF_W'(prev_err_ff);
   assign d_prod    = d_diff * $signed({1'b0, cfg.gain_d20});
   assign d_lim_pos = DPROD_W'(DERIV_MAX);
   assign d_lim_neg = -d_lim_pos;

   always_comb begin
      if (d_prod > d_lim_pos) begin
         d_sat = HELD_W'(d_lim_pos);
      end else if (d_prod < d_lim_neg) begin
         d_sat = HELD_W'(d_lim_neg);
      end else begin
         d_sat = HELD_W'(d_prod);
      end
   end

   assign d_b_in = d_fire ? d_sat : held_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         prev_err_ff <= '0;
         held_d_ff   <= '0;
      end else if (ld_b && va_ff) begin
         tick_ff <= tick_in;
         if (d_fire) begin
            held_d_ff   <= d_sat;
            prev_err_ff <= err_a_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld_b) begin
         inc_b_ff <= inc_b_in;
         p_b_ff   <= p_b_in;
         d_b_ff   <= d_b_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage C: accumulate with saturation, then windup clamp for storage.
   // The I term uses the unclamped value.
   // ---------------------------------------------------------------------
   logic signed [ACC_W:0]     acc_sum, acc_lim_pos, acc_lim_neg;
   logic signed [ACC_W-1:0]   acc_ff, acc_sat, acc_in, acc_c_ff;
   logic signed [LIMQ_W-1:0]  lim_q;
   logic signed [CMP_W-1:0]   acc_cmp, lim_cmp;
   logic                      inc_pos, inc_neg;
   logic signed [PD_W-1:0]    pd_c_in, pd_c_ff;

   assign acc_sum     = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(inc_b_ff);
   assign acc_lim_pos = (ACC_W+1)'(ACC_MAX);
   assign acc_lim_neg = -acc_lim_pos;

   always_comb begin
      if (acc_sum > acc_lim_pos) begin
         acc_sat = ACC_W'(acc_lim_pos);
      end else if (acc_sum < acc_lim_neg) begin
         acc_sat = ACC_W'(acc_lim_neg);
      end else begin
         acc_sat = ACC_W'(acc_sum);
      end
   end

   // increment sign equals error sign (nonzero error gives nonzero step)
   assign inc_neg = inc_b_ff[INC_W-1];
   assign inc_pos = !inc_neg && (inc_b_ff != '0);

   assign lim_q   = $signed(LIMQ_W'(cfg.windup_limit) << INTEG_FRAC_BITS);
   assign acc_cmp = CMP_W'(acc_sat);
   assign lim_cmp = CMP_W'(lim_q);

   always_comb begin
      if (inc_pos && (acc_cmp >= lim_cmp)) begin
         acc_in = ACC_W'(lim_cmp);
      end else if (inc_neg && (acc_cmp <= -lim_cmp)) begin
         acc_in = ACC_W'(-lim_cmp);
      end else begin
         acc_in = acc_sat;
      end
   end

   assign pd_c_in = PD_W'(p_b_ff) + PD_W'(d_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ld_c && vb_ff) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_c) begin
         acc_c_ff <= acc_sat;
         pd_c_ff  <= pd_c_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage D: I product
   // ---------------------------------------------------------------------
   logic signed [I_W-1:0]  i_d_in, i_d_ff;
   logic signed [PD_W-1:0] pd_d_ff;

   assign i_d_in = acc_c_ff * $signed({1'b0, cfg.gain_i});

   always_ff @(posedge clock) begin
      if (ld_d) begin
         i_d_ff  <= i_d_in;
         pd_d_ff <= pd_c_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage E: align all terms to Q.(TEMP+INTEG+GAIN) and sum
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] sum_e_in, sum_e_ff;

   assign sum_e_in = (SUM_W'(pd_d_ff) <<< INTEG_FRAC_BITS)
                   + (SUM_W'(i_d_ff) <<< TEMP_FRAC_BITS);

   always_ff @(posedge clock) begin
      if (ld_e) sum_e_ff <= sum_e_in;
   end

   // ---------------------------------------------------------------------
   // Stage F: round half away from zero, clamp to 0..DRIVE_MAX
   // ---------------------------------------------------------------------
   logic signed [SUM_W-1:0] rnd_full;
   logic signed [RND_W-1:0] rnd, rnd_max;
   logic [DRIVE_W-1:0]      drive_in, drive_ff;
   logic                    hi_in, lo_in, hi_ff, lo_ff;

   // negative sums get half minus one, so ties move away from zero
   assign rnd_full = sum_e_ff + (SUM_W'(1) <<< (RND_SHIFT - 1))
                   - SUM_W'(sum_e_ff[SUM_W-1]);
   assign rnd      = $signed(rnd_full[SUM_W-1:RND_SHIFT]);
   assign rnd_max  = RND_W'(DRIVE_MAX);

   always_comb begin
      hi_in    = 1'b0;
      lo_in    = 1'b0;
      drive_in = rnd[DRIVE_W-1:0];
      if (rnd > rnd_max) begin
         hi_in    = 1'b1;
         drive_in = DRIVE_W'(DRIVE_MAX);
      end else if (rnd < 0) begin
         lo_in    = 1'b1;
         drive_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_f) begin
         drive_ff <= drive_in;
         hi_ff    <= hi_in;
         lo_ff    <= lo_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive        = drive_ff;
   assign rsp_clipped_high = hi_ff;
   assign rsp_clipped_low  = lo_ff;

endmodule

// File: rtl/pidad_checker.sv
module pidad_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [pidad_pkg::DRIVE_W-1:0]     rsp_drive,
   input logic                              rsp_clipped_high,
   input logic                              rsp_clipped_low
);
   import pidad_pkg::*;

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive)
         && $stable(rsp_clipped_high) && $stable(rsp_clipped_low))
      else $error("stalled response changed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive <= DRIVE_W'(DRIVE_MAX))
      else $error("drive above limit");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_clipped_high && rsp_clipped_low))
      else $error("both clip flags set");

   a_high_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_high |-> rsp_drive == DRIVE_W'(DRIVE_MAX))
      else $error("high clip without full drive");

   a_low_val: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped_low |-> rsp_drive == '0)
      else $error("low clip with nonzero drive");

endmodule

bind pid_antiwindup_decimated_derivative_core pidad_checker u_pidad_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_drive        (rsp_drive),
   .rsp_clipped_high (rsp_clipped_high),
   .rsp_clipped_low  (rsp_clipped_low)
);

// File: bench/pid_antiwindup_decimated_derivative_checker.sv
module pid_antiwindup_decimated_derivative_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_stall,
   input  logic [pidad_pkg::SETPOINT_W-1:0] req_setpoint,
   input  logic [pidad_pkg::TEMP_W-1:0]     req_measured_temp,
   input  logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  logic [pidad_pkg::DRIVE_W-1:0]    rsp_drive,
   input  logic                             rsp_clipped_high,
   input  logic                             rsp_clipped_low,
   input  logic                             csr_wen,
   input  pidad_pkg::csr_index_type         csr_index,
   input  logic [pidad_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                               mismatch_count,
   output int                               pending_count,
   output int                               checked_count,
   output int                               high_count,
   output int                               low_count,
   output int                               clamp_count,
   output int                               refresh_count,
   output int                               backpressure_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pidad_pkg::*;

   typedef struct packed {
      logic [DRIVE_W-1:0] drive;
      logic               clipped_high;
      logic               clipped_low;
   } drive_result_type;

   drive_result_type drive_due_q[$];

   // shadow of the register file
   logic [GAIN_P_W-1:0] kp;
   logic [GAIN_I_W-1:0] ki;
   logic [GAIN_D_W-1:0] kd;
   logic [LIMIT_W-1:0]  windup;
   logic [PERIOD_W-1:0] period;

   // controller state
   logic signed [ACC_W-1:0]  acc;
   logic signed [ERR_W-1:0]  last_err;
   logic [PERIOD_W-1:0]      ticks;
   logic signed [HELD_W-1:0] held_d;

   // half away from zero, den > 0
   function automatic longint div_half_away(longint num, longint den);
      longint mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
   endfunction

   function automatic longint clamp_sym(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   task automatic step_controller(input logic [SETPOINT_W-1:0] sp,
                                  input logic [TEMP_W-1:0] meas,
                                  output drive_result_type res);
      longint err, p_val, i_val, acc_v, lim_q, d_val, sum, rounded;
      err   = (longint'(sp) <<< TEMP_FRAC_BITS) - longint'(meas);
      p_val = err * longint'(kp);

      // I term uses the sum before the windup clamp
      acc_v = clamp_sym(longint'(acc) +
                        div_half_away(err <<< INTEG_FRAC_BITS,
                                      longint'(INTEG_DIVISOR) <<< TEMP_FRAC_BITS),
                        ACC_MAX);
      i_val = acc_v * longint'(ki);
      lim_q = longint'(windup) <<< INTEG_FRAC_BITS;
      if (acc_v >= lim_q && err > 0) begin
         acc_v = lim_q;
         clamp_count++;
      end else if (acc_v <= -lim_q && err < 0) begin
         acc_v = -lim_q;
         clamp_count++;
      end
      acc = acc_v[ACC_W-1:0];

      ticks = ticks + PERIOD_W'(1);
      if (ticks >= period) begin
         d_val    = clamp_sym((err - longint'(last_err)) * longint'(kd) * DERIV_SCALE,
                              DERIV_MAX);
         held_d   = d_val[HELD_W-1:0];
         last_err = err[ERR_W-1:0];
         ticks    = '0;
         refresh_count++;
      end

      sum = (p_val <<< INTEG_FRAC_BITS) + (i_val <<< TEMP_FRAC_BITS)
          + (longint'(held_d) <<< INTEG_FRAC_BITS);
      rounded = div_half_away(sum, longint'(1) <<< RND_SHIFT);

      res = '0;
      if (rounded > DRIVE_MAX) begin
         res.drive        = DRIVE_W'(DRIVE_MAX);
         res.clipped_high = 1'b1;
      end else if (rounded < 0) begin
         res.clipped_low = 1'b1;
      end else begin
         res.drive = rounded[DRIVE_W-1:0];
      end
   endtask

   always @(posedge clock) begin
      drive_result_type want;
      if (reset) begin
         kp       = GAIN_P_RST;
         ki       = GAIN_I_RST;
         kd       = GAIN_D_W'(GD20_RST / DERIV_SCALE);
         windup   = LIMIT_RST;
         period   = PERIOD_RST;
         acc      = '0;
         last_err = '0;
         ticks    = '0;
         held_d   = '0;
         drive_due_q.delete();
      end else begin
         if (csr_wen) begin
            case (csr_index)
               CSR_GAIN_P:       kp     = csr_wdata[GAIN_P_W-1:0];
               CSR_GAIN_I:       ki     = csr_wdata[GAIN_I_W-1:0];
               CSR_GAIN_D:       kd     = csr_wdata[GAIN_D_W-1:0];
               CSR_WINDUP_LIMIT: windup = csr_wdata[LIMIT_W-1:0];
               CSR_DERIV_PERIOD: period = csr_wdata[PERIOD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_stall)
            backpressure_count++;
         if (req_valid && !req_stall) begin
            step_controller(req_setpoint, req_measured_temp, want);
            drive_due_q.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (drive_due_q.size() == 0) begin
               $error("unexpected response: drive %0d high %0b low %0b",
                      rsp_drive, rsp_clipped_high, rsp_clipped_low);
               mismatch_count++;
            end else begin
               want = drive_due_q.pop_front();
               checked_count++;
               if (want.clipped_high) high_count++;
               if (want.clipped_low) low_count++;
               if (rsp_drive !== want.drive) begin
                  $error("drive: expected %0d, got %0d", want.drive, rsp_drive);
                  mismatch_count++;
               end
               if (rsp_clipped_high !== want.clipped_high) begin
                  $error("clipped_high: expected %0b, got %0b",
                         want.clipped_high, rsp_clipped_high);
                  mismatch_count++;
               end
               if (rsp_clipped_low !== want.clipped_low) begin
                  $error("clipped_low: expected %0b, got %0b",
                         want.clipped_low, rsp_clipped_low);
                  mismatch_count++;
               end
            end
         end
      end
      pending_count = drive_due_q.size();
   end

endmodule

// File: bench/pid_antiwindup_decimated_derivative_core_tb.sv
module pid_antiwindup_decimated_derivative_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidad_pkg::*;

   localparam int SETPOINT_MAX     = 255;
   localparam int TEMP_MAX         = 84480;   // 330 C in Q.8
   localparam int SOAK_TICKS       = 650;     // enough to pin the accumulator at its rail
   localparam int LONG_HOLD_CYCLES = 80;      // far longer than the 6-stage pipe
   localparam int TAIL_CYCLES      = 20;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [SETPOINT_W-1:0] req_setpoint;
   logic [TEMP_W-1:0]     req_measured_temp;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [DRIVE_W-1:0]    rsp_drive;
   logic                  rsp_clipped_high;
   logic                  rsp_clipped_low;
   logic                  csr_wen;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int mismatch_count, pending_count, checked_count, high_count, low_count;
   int clamp_count, refresh_count, backpressure_count;

   // stimulus shaping state
   int seg_left, seg_sp, seg_bias;
   bit seg_burst;
   int burst_left;
   bit hold_request;   // main thread asks the response side for one long hold-off
   int sent_count;

   pid_antiwindup_decimated_derivative_core dut (.*);

   pid_antiwindup_decimated_derivative_checker drive_check (.*);

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Hard stop in case the handshake locks up.
   initial begin
      #5ms;
      $display("status: fail");
      $finish;
   end

   // Response side: stall density changes between random-length segments (including
   // stretches of zero), with the odd long stall and one long hold-off on
   // request so the pipe backs up all the way to req_stall.
   initial begin
      int  hold_left, mode_left, pct;
      logic stall;
      hold_left = 0;
      mode_left = 0;
      pct       = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         stall = 1'b0;
         if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD_CYCLES - 1;
            stall        = 1'b1;
         end else begin
            if (mode_left == 0) begin
               case ($urandom_range(0, 4))
                  0, 1:    pct = 0;
                  2:       pct = 15;
                  3:       pct = 40;
                  default: pct = 80;
               endcase
               mode_left = $urandom_range(20, 120);
            end else begin
               mode_left--;
            end
            if ($urandom_range(0, 99) < pct) begin
               stall = 1'b1;
               if ($urandom_range(0, 99) < 3)
                  hold_left = $urandom_range(8, 30);
            end
         end
         rsp_stall <= stall;
      end
   end

   // Idle cycles before the next request: mostly none, a few long ones.
   function automatic int idle_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if (seg_burst) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 9);
      return $urandom_range(10, 30);
   endfunction

   // Present one tick at the falling edge and hold it until taken.
   // Valid stays high across back-to-back requests.
   task automatic send_tick(input int sp, input int meas);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_setpoint      <= SETPOINT_W'(sp);
      req_measured_temp <= TEMP_W'(meas);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   // Plant-like ticks: segments hold a setpoint and a steady error bias so the
   // integrator actually winds up and the clamp engages; some noise and
   // corner values are mixed in.
   task automatic make_tick(output int sp, output int meas);
      int r, span, m;
      if (seg_left == 0) begin
         seg_left = $urandom_range(5, 80);
         seg_sp   = $urandom_range(0, SETPOINT_MAX);
         case ($urandom_range(0, 3))
            0:       span = 256;
            1:       span = 4096;
            2:       span = 40000;
            default: span = TEMP_MAX;
         endcase
         seg_bias  = int'($urandom_range(0, 2 * span)) - span;
         seg_burst = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      r = $urandom_range(0, 99);
      if (r < 10) begin
         sp   = $urandom_range(0, SETPOINT_MAX);
         meas = $urandom_range(0, TEMP_MAX);
      end else if (r < 14) begin
         sp   = $urandom_range(0, 1) ? SETPOINT_MAX : 0;
         meas = $urandom_range(0, 1) ? TEMP_MAX : 0;
      end else begin
         sp = seg_sp;
         m  = (seg_sp << TEMP_FRAC_BITS) - seg_bias + int'($urandom_range(0, 128)) - 64;
         if (m < 0) m = 0;
         if (m > TEMP_MAX) m = TEMP_MAX;
         meas = m;
      end
   endtask

   task automatic run_random(input int count);
      int sp;
      int meas;
      repeat (count) begin
         make_tick(sp, meas);
         send_tick(sp, meas);
      end
   endtask

   // Drop valid and wait until every request has come back.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // One write per cycle; wen stays up across a batch, caller lowers it.
   task automatic csr_write(input csr_index_type idx, input int data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(negedge clock);
   endtask

   task automatic apply_settings(input int kp, input int ki, input int kd,
                                 input int lim, input int per);
      quiesce();
      csr_write(CSR_GAIN_P, kp);
      csr_write(CSR_GAIN_I, ki);
      csr_write(CSR_GAIN_D, kd);
      csr_write(CSR_WINDUP_LIMIT, lim);
      csr_write(CSR_DERIV_PERIOD, per);
      csr_wen <= 1'b0;
   endtask

   task automatic random_settings();
      apply_settings($urandom_range(0, 40960), $urandom_range(0, 10240),
                     $urandom_range(0, 30720),
                     $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom_range(0, 65535),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                 : $urandom_range(1, 12));
   endtask

   initial begin
      int meas;
      req_valid         = 1'b0;
      req_setpoint      = '0;
      req_measured_temp = '0;
      csr_wen           = 1'b0;
      csr_index         = CSR_GAIN_P;
      csr_wdata         = '0;
      reset             = 1'b1;
      seg_left          = 0;
      seg_burst         = 1'b0;
      burst_left        = 0;
      hold_request      = 1'b0;
      sent_count        = 0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, register defaults. Zero error first, then errors of one LSB
      // either way (the negative one must round to drive 0 with no flag).
      send_tick(0, 0);
      send_tick(100, 100 * 256 + 1);
      send_tick(100, 100 * 256 - 1);
      send_tick(SETPOINT_MAX, SETPOINT_MAX * 256);
      send_tick(SETPOINT_MAX, 0);
      send_tick(0, TEMP_MAX);
      send_tick(SETPOINT_MAX, TEMP_MAX);
      send_tick(0, 1);
      send_tick(SETPOINT_MAX, SETPOINT_MAX * 256 - 1);
      send_tick(128, 0);
      // hold max error in each direction so the integral swings
      repeat (6) send_tick(SETPOINT_MAX, 0);
      repeat (6) send_tick(0, TEMP_MAX);
      run_random(100);

      // Largest test gains, max limit, D refresh every tick. The soak drives the
      // accumulator into its own saturation since this limit is unreachable.
      apply_settings(40960, 10240, 30720, 65535, 1);
      repeat (SOAK_TICKS) begin
         meas = $urandom_range(83500, TEMP_MAX);
         send_tick(0, meas);
      end
      // alternating extremes saturate the D term
      repeat (4) begin
         send_tick(SETPOINT_MAX, 0);
         send_tick(0, TEMP_MAX);
      end
      run_random(40);

      // Zero windup limit and period zero (refresh on every tick).
      apply_settings($urandom_range(0, 40960), $urandom_range(0, 10240),
                     $urandom_range(0, 30720), 0, 0);
      run_random(80);

      // All gains zero, longest period.
      apply_settings(0, 0, 0, $urandom_range(0, 65535), 65535);
      run_random(80);

      // Period lowered below the running tick count; small limit so the
      // clamp engages. Long hold-off on the response side while requests
      // keep coming back to back.
      apply_settings($urandom_range(0, 40960), $urandom_range(0, 10240),
                     $urandom_range(0, 30720), $urandom_range(1, 20),
                     $urandom_range(2, 40));
      hold_request = 1'b1;
      burst_left   = 120;
      run_random(150);

      // Writes above the last register index must be ignored.
      quiesce();
      for (int k = 1; k <= 3; k++)
         csr_write(csr_index_type'(CSR_DERIV_PERIOD + k), $urandom_range(0, 65535));
      random_settings();
      run_random(80);

      repeat (3) begin
         random_settings();
         run_random(80);
      end

      quiesce();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d requests, %0d responses checked, %0d cycles of input backpressure",
               sent_count, checked_count, backpressure_count);
      $display("drive clipped high %0d and low %0d times, integrator clamped %0d times,",
               high_count, low_count, clamp_count);
      $display("D refreshed %0d times", refresh_count);
      if (mismatch_count == 0 && pending_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: files.f
rtl/pidad_pkg.sv
rtl/pidad_csr.sv
rtl/pid_antiwindup_decimated_derivative_core.sv
rtl/pidad_checker.sv
bench/pid_antiwindup_decimated_derivative_checker.sv
bench/pid_antiwindup_decimated_derivative_core_tb.sv
